// ===== rtl/postfix_expression_evaluator_unit_defines.svh =====
// Assertion macros for the postfix expression evaluator.
// Each macro checks a property on the rising edge of clk_i and is disabled
// while rst_ni is low.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// The consequent holds in the same cycle as the antecedent.
`define PFE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfe assertion failed");
// The consequent holds in the cycle after the antecedent.
`define PFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfe assertion failed");
`else
`define PFE_ASSERT_SAME(lbl, ante, cons)
`define PFE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator package
// Shared constants, status codes, token and state types.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned QueueDepth        = 4;

  // Character codes of the expression alphabet.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharStar  = 8'h2A;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef enum logic [2:0] {
    STATUS_OK        = 3'd0,
    STATUS_UNDERFLOW = 3'd1,
    STATUS_OVERFLOW  = 3'd2,
    STATUS_DIVZERO   = 3'd3,
    STATUS_UNKNOWN   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    KIND_DIGIT,
    KIND_SPACE,
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_UNKNOWN
  } kind_e;

  // One classified character as it travels through the queue.
  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_REFILL,
    BK_EMIT
  } back_state_e;

  // Status of the execution side, seen by the top level.
  typedef struct packed {
    logic idle;
    logic dividing;
  } back_status_t;

endpackage

// ===== rtl/pfe_front.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator front end
// Accepts characters and classifies them into tokens, one register deep.
// ----------------------------------------------------------------------------
module pfe_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      char_code_i,
  input  logic            last_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pfe_pkg::token_t tok_o
);

  logic            valid_q, valid_d;
  pfe_pkg::token_t tok_q, tok_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign tok_o   = tok_q;

  // Classify the incoming character.
  always_comb begin
    tok_d.last  = last_i;
    tok_d.digit = 4'(char_code_i - pfe_pkg::CharZero);
    if (char_code_i >= pfe_pkg::CharZero && char_code_i <= pfe_pkg::CharNine) begin
      tok_d.kind = pfe_pkg::KIND_DIGIT;
    end else if (char_code_i == pfe_pkg::CharSpace) begin
      tok_d.kind = pfe_pkg::KIND_SPACE;
    end else if (char_code_i == pfe_pkg::CharPlus) begin
      tok_d.kind = pfe_pkg::KIND_ADD;
    end else if (char_code_i == pfe_pkg::CharMinus) begin
      tok_d.kind = pfe_pkg::KIND_SUB;
    end else if (char_code_i == pfe_pkg::CharStar) begin
      tok_d.kind = pfe_pkg::KIND_MUL;
    end else if (char_code_i == pfe_pkg::CharSlash) begin
      tok_d.kind = pfe_pkg::KIND_DIV;
    end else begin
      tok_d.kind = pfe_pkg::KIND_UNKNOWN;
    end
  end

  // Hold the word until the queue takes it.
  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      tok_q <= tok_d;
    end
  end

endmodule

// ===== rtl/pfe_fifo.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator token queue
// Small FIFO that decouples classification from execution.
// ----------------------------------------------------------------------------
module pfe_fifo #(
  parameter int unsigned Depth = pfe_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pfe_pkg::token_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pfe_pkg::token_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pfe_pkg::token_t entries_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = entries_q[rptr_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/pfe_div.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator divider
// Signed 32-bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfe_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  steps_q, steps_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dsr_q, dsr_d;
  logic        neg_q, neg_d;
  logic [32:0] shifted, diff;

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? 32'(-quo_q) : quo_q;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dsr_q};

  // Load magnitudes on start, then one trial subtraction per cycle.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    steps_d = steps_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    neg_d   = neg_q;
    if (start_i) begin
      busy_d  = 1'b1;
      steps_d = 6'd32;
      rem_d   = '0;
      quo_d   = dividend_i[31] ? 32'(-dividend_i) : dividend_i;
      dsr_d   = divisor_i[31] ? 32'(-divisor_i) : divisor_i;
      neg_d   = dividend_i[31] ^ divisor_i[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      steps_d = steps_q - 1'b1;
      if (steps_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      steps_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

endmodule

// ===== rtl/pfe_back.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator execution unit
// Operand stack with the two top entries in registers, arithmetic, the
// sticky status and the result register.
// ----------------------------------------------------------------------------
module pfe_back #(
  parameter int unsigned StackDepth = pfe_pkg::StackDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tok_valid_i,
  output logic                  tok_ready_o,
  input  pfe_pkg::token_t       tok_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [31:0]           result_o,
  output pfe_pkg::status_e      status_o,
  output pfe_pkg::back_status_t stat_o
);

  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  pfe_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [31:0]          tos_q, tos_d, nos_q, nos_d;
  pfe_pkg::status_e     err_q, err_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  logic [31:0]          out_value_q, out_value_d;
  pfe_pkg::status_e     out_status_q, out_status_d;

  // Stack memory below the two cached entries.
  logic [31:0]          mem [StackDepth];
  logic [31:0]          rd_q;
  logic                 mem_we;
  logic [AddrW-1:0]     waddr, raddr;

  logic        take, has2, has3, full, arith, div_go, out_free;
  logic        div_busy, div_done;
  logic [31:0] arith_res, div_quo;

  function automatic pfe_pkg::status_e sticky(pfe_pkg::status_e cur,
                                              pfe_pkg::status_e code);
    return (cur == pfe_pkg::STATUS_OK) ? code : cur;
  endfunction

  assign tok_ready_o = state_q == pfe_pkg::BK_IDLE;
  assign take        = tok_valid_i && tok_ready_o;
  assign has2        = count_q >= CntW'(2);
  assign has3        = count_q >= CntW'(3);
  assign full        = count_q == CntW'(StackDepth);
  assign arith       = has2 && (tok_i.kind == pfe_pkg::KIND_ADD ||
                                tok_i.kind == pfe_pkg::KIND_SUB ||
                                tok_i.kind == pfe_pkg::KIND_MUL);
  assign div_go      = take && has2 && tok_i.kind == pfe_pkg::KIND_DIV && tos_q != '0;
  assign out_free    = !out_valid_q || out_ready_i;
  assign waddr       = AddrW'(count_q - CntW'(2));
  assign raddr       = AddrW'(count_q - CntW'(3));

  assign out_valid_o = out_valid_q;
  assign result_o    = out_value_q;
  assign status_o    = out_status_q;
  assign stat_o      = '{idle: state_q == pfe_pkg::BK_IDLE, dividing: div_busy};

  // Add, subtract and low half of the product, left operand below the top.
  always_comb begin
    case (tok_i.kind)
      pfe_pkg::KIND_ADD: arith_res = nos_q + tos_q;
      pfe_pkg::KIND_SUB: arith_res = nos_q - tos_q;
      default:           arith_res = nos_q * tos_q;
    endcase
  end

  pfe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go),
    .dividend_i (nos_q),
    .divisor_i  (tos_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfe_pkg::BK_IDLE: begin
        if (take) begin
          if (arith && has3) begin
            state_d = pfe_pkg::BK_REFILL;
          end else if (div_go) begin
            state_d = pfe_pkg::BK_DIV;
          end else if (tok_i.last) begin
            state_d = pfe_pkg::BK_EMIT;
          end
        end
      end
      pfe_pkg::BK_DIV: begin
        if (div_done) begin
          if (has3) begin
            state_d = pfe_pkg::BK_REFILL;
          end else if (last_q) begin
            state_d = pfe_pkg::BK_EMIT;
          end else begin
            state_d = pfe_pkg::BK_IDLE;
          end
        end
      end
      pfe_pkg::BK_REFILL: begin
        state_d = last_q ? pfe_pkg::BK_EMIT : pfe_pkg::BK_IDLE;
      end
      pfe_pkg::BK_EMIT: begin
        if (out_free) begin
          state_d = pfe_pkg::BK_IDLE;
        end
      end
      default: state_d = pfe_pkg::BK_IDLE;
    endcase
  end

  // Stack, status and result updates.
  always_comb begin
    count_d      = count_q;
    tos_d        = tos_q;
    nos_d        = nos_q;
    err_d        = err_q;
    last_d       = last_q;
    mem_we       = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    unique case (state_q)
      pfe_pkg::BK_IDLE: begin
        if (take) begin
          last_d = tok_i.last;
          case (tok_i.kind)
            pfe_pkg::KIND_DIGIT: begin
              if (full) begin
                err_d = sticky(err_q, pfe_pkg::STATUS_OVERFLOW);
              end else begin
                mem_we  = has2;
                nos_d   = tos_q;
                tos_d   = {28'd0, tok_i.digit};
                count_d = count_q + 1'b1;
              end
            end
            pfe_pkg::KIND_SPACE: begin
            end
            pfe_pkg::KIND_UNKNOWN: begin
              err_d = sticky(err_q, has2 ? pfe_pkg::STATUS_UNKNOWN
                                         : pfe_pkg::STATUS_UNDERFLOW);
            end
            default: begin
              if (!has2) begin
                err_d = sticky(err_q, pfe_pkg::STATUS_UNDERFLOW);
              end else if (tok_i.kind == pfe_pkg::KIND_DIV) begin
                if (tos_q == '0) begin
                  err_d = sticky(err_q, pfe_pkg::STATUS_DIVZERO);
                end
              end else begin
                tos_d   = arith_res;
                count_d = count_q - 1'b1;
              end
            end
          endcase
        end
      end
      pfe_pkg::BK_DIV: begin
        if (div_done) begin
          tos_d   = div_quo;
          count_d = count_q - 1'b1;
        end
      end
      pfe_pkg::BK_REFILL: begin
        nos_d = rd_q;
      end
      pfe_pkg::BK_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = (count_q == '0) ? '0 : tos_q;
          out_status_d = (count_q == '0) ? sticky(err_q, pfe_pkg::STATUS_UNDERFLOW)
                                         : err_q;
          count_d      = '0;
          err_d        = pfe_pkg::STATUS_OK;
          last_d       = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfe_pkg::BK_IDLE;
      count_q     <= '0;
      err_q       <= pfe_pkg::STATUS_OK;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q        <= tos_d;
    nos_q        <= nos_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // Stack memory: one write port for spills, one registered read for refills.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= nos_q;
    end
    rd_q <= mem[raddr];
  end

endmodule

// ===== rtl/postfix_expression_evaluator_unit.sv =====
// Channel   Direction  tdata                            tlast
// s_axis    in         [7:0] char_code                  end_of_expression
// m_axis    out        [31:0] result_value, [34:32] status  none
//
// Digits, spaces and unknown characters are handled in the idle state.
// Add, subtract and multiply likewise, then REFILL if a refill follows.
// Divide waits in the DIV state for the bit-serial divider.
// After the last character, EMIT loads the result; reset clears all control.
// Either side may stall: a four-word token queue and the result register
// keep the input and output sides apart.
// ----------------------------------------------------------------------------
// Postfix expression evaluator
// Evaluates single-digit postfix expressions on a 32-bit operand stack.
// ----------------------------------------------------------------------------
`include "postfix_expression_evaluator_unit_defines.svh"

module postfix_expression_evaluator_unit #(
  parameter int unsigned StackDepth = pfe_pkg::StackDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_code
  input  logic        s_axis_tlast,  // end_of_expression
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] result_value, [34:32] status
);

  logic                  fr_valid, fr_ready, q_valid, q_ready;
  pfe_pkg::token_t       fr_tok, q_tok;
  logic [31:0]           result;
  pfe_pkg::status_e      status;
  pfe_pkg::back_status_t bk_stat;

  pfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .char_code_i (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .valid_o     (fr_valid),
    .ready_i     (fr_ready),
    .tok_o       (fr_tok)
  );

  pfe_fifo #(
    .Depth (pfe_pkg::QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  (fr_tok),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_tok)
  );

  pfe_back #(
    .StackDepth (StackDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_ready_o (q_ready),
    .tok_i       (q_tok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result),
    .status_o    (status),
    .stat_o      (bk_stat)
  );

  assign m_axis_tdata = {5'd0, status, result};

  // A word accepted at the input sits in the front register next cycle.
  `PFE_ASSERT_NEXT(a_front_loaded, s_axis_tvalid && s_axis_tready, fr_valid)
  // The execution unit never takes a token while the divider runs.
  `PFE_ASSERT_SAME(a_div_blocks_queue, bk_stat.dividing, !q_ready && !bk_stat.idle)
  // Results carry only defined status codes.
  `PFE_ASSERT_SAME(a_status_code, m_axis_tvalid,
                   status == pfe_pkg::STATUS_OK || status == pfe_pkg::STATUS_UNDERFLOW ||
                   status == pfe_pkg::STATUS_OVERFLOW || status == pfe_pkg::STATUS_DIVZERO ||
                   status == pfe_pkg::STATUS_UNKNOWN)
  // A token is consumed only when the execution unit is idle.
  `PFE_ASSERT_SAME(a_pop_when_idle, q_valid && q_ready, bk_stat.idle && !bk_stat.dividing)

endmodule

// ===== test/postfix_expression_evaluator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Postfix evaluator testbench
// Streams postfix expressions into the evaluator with random idle bursts on
// both sides and checks every result word against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_expression_evaluator_unit_tb;

  localparam int unsigned Depth = pfe_pkg::StackDepthDefault;
  localparam int unsigned QuietLimit = 4000;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } char_word_t;

  typedef struct packed {
    logic [31:0]      value;
    pfe_pkg::status_e status;
  } result_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  // Predictor state.
  logic [31:0]      eval_stack [Depth];
  int unsigned      eval_count;
  pfe_pkg::status_e eval_status;

  char_word_t   pending_chars [$];
  result_word_t expected_results [$];
  bit  failed;
  bit  stim_done;
  bit  calm;
  bit  hold_send;
  bit  in_fire;
  int  send_gap;
  int  recv_gap;
  int  quiet_cycles;

  postfix_expression_evaluator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Keeps only the first fault of an expression.
  function automatic void note_fault(pfe_pkg::status_e code);
    if (eval_status == pfe_pkg::STATUS_OK) eval_status = code;
  endfunction

  // Advances the predicted stack by one character; queues a result on last.
  function automatic void evaluate_char(char_word_t w);
    logic [31:0] rhs, lhs, res;
    bit          is_op;
    rhs = '0;
    lhs = '0;
    res = '0;
    is_op = (w.char_code == pfe_pkg::CharPlus) || (w.char_code == pfe_pkg::CharMinus) ||
            (w.char_code == pfe_pkg::CharStar) || (w.char_code == pfe_pkg::CharSlash);
    if (w.char_code >= pfe_pkg::CharZero && w.char_code <= pfe_pkg::CharNine) begin
      if (eval_count >= Depth) note_fault(pfe_pkg::STATUS_OVERFLOW);
      else begin
        eval_stack[eval_count] = 32'(w.char_code - pfe_pkg::CharZero);
        eval_count++;
      end
    end else if (w.char_code != pfe_pkg::CharSpace) begin
      if (eval_count < 2) note_fault(pfe_pkg::STATUS_UNDERFLOW);
      else if (!is_op) note_fault(pfe_pkg::STATUS_UNKNOWN);
      else begin
        rhs = eval_stack[eval_count-1];
        lhs = eval_stack[eval_count-2];
        if (w.char_code == pfe_pkg::CharSlash && rhs == 0) begin
          note_fault(pfe_pkg::STATUS_DIVZERO);
        end else begin
          case (w.char_code)
            pfe_pkg::CharPlus:  res = lhs + rhs;
            pfe_pkg::CharMinus: res = lhs - rhs;
            pfe_pkg::CharStar:  res = lhs * rhs;
            default: begin
              // Minimum over minus one wraps back to the minimum.
              if (lhs == 32'h8000_0000 && rhs == '1) res = lhs;
              else res = $signed(lhs) / $signed(rhs);
            end
          endcase
          eval_count--;
          eval_stack[eval_count-1] = res;
        end
      end
    end
    if (w.last) begin
      if (eval_count == 0) begin
        note_fault(pfe_pkg::STATUS_UNDERFLOW);
        res = '0;
      end else res = eval_stack[eval_count-1];
      expected_results.push_back('{value: res, status: eval_status});
      eval_count = 0;
      eval_status = pfe_pkg::STATUS_OK;
    end
  endfunction

  function automatic void add_char(logic [7:0] c, logic l);
    pending_chars.push_back('{char_code: c, last: l});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
  endfunction

  // Random operand character, biased toward zero.
  function automatic logic [7:0] rand_digit();
    return (($urandom_range(0, 3) == 0) ? pfe_pkg::CharZero :
            8'($urandom_range(pfe_pkg::CharZero, pfe_pkg::CharNine)));
  endfunction

  function automatic logic [7:0] rand_op();
    logic [7:0] ops [4];
    ops = '{pfe_pkg::CharPlus, pfe_pkg::CharMinus, pfe_pkg::CharStar, pfe_pkg::CharSlash};
    return ops[$urandom_range(0, 3)];
  endfunction

  // Builds a well-formed expression, with occasional noise characters.
  function automatic int add_random_expr();
    int n, depth_now, emitted, pick;
    logic [7:0] c;
    n = $urandom_range(1, 12);
    depth_now = 0;
    emitted = 0;
    for (int i = 0; i < n || depth_now > 1; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) c = 8'($urandom_range(0, 255));
      else if (pick < 10) c = pfe_pkg::CharSpace;
      else if (depth_now >= 2 && (pick < 50 || i >= n)) begin
        c = rand_op();
        depth_now--;
      end else begin
        c = rand_digit();
        depth_now++;
      end
      add_char(c, 1'b0);
      emitted++;
    end
    pending_chars[$].last = 1'b1;
    return emitted;
  endfunction

  // Stimulus.
  initial begin
    int total;
    string s;
    rst_ni = 1'b0;
    failed = 1'b0;
    stim_done = 1'b0;
    calm = 1'b0;
    hold_send = 1'b0;
    eval_count = 0;
    eval_status = pfe_pkg::STATUS_OK;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: each operator, faults, extremes of the character code.
    add_text("93-");
    add_text("78*");
    add_text("8 3/");
    add_text("90-7/");
    add_text("50/");
    add_text("+");
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b1);
    add_text("12a");
    add_text("1");
    add_text(" ");
    add_text("3+4");
    add_text("05-2/");
    total = pending_chars.size();
    while (pending_chars.size() != 0) @(negedge clk_i);

    // Build the minimum value, then divide it by minus one; also overflow.
    s = "01-";
    for (int i = 0; i < 31; i++) s = {s, "2*"};
    s = {s, "01-/"};
    add_text(s);
    total += s.len();
    s = "";
    for (int i = 0; i < Depth + 2; i++) s = {s, "9"};
    add_text(s);
    total += s.len();
    // Wide wraps of multiply and add.
    s = "9";
    for (int i = 0; i < 12; i++) s = {s, "9*"};
    s = {s, "9+"};
    add_text(s);
    total += s.len();

    // Sender pauses until every result has come back.
    while (pending_chars.size() != 0) @(negedge clk_i);
    hold_send = 1'b1;
    while (expected_results.size() != 0) @(negedge clk_i);
    hold_send = 1'b0;

    while (total < 1150) begin
      total += add_random_expr();
      if (total > 950) calm = 1'b1;
      while (pending_chars.size() > 40) @(negedge clk_i);
    end
    while (pending_chars.size() != 0) @(negedge clk_i);
    stim_done = 1'b1;
  end

  // Input acceptance: predicts each word at the edge that takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        evaluate_char(pending_chars.pop_front());
      end
    end
  end

  // Driver: presents a new word once the previous one has been taken.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      send_gap      <= 0;
    end else begin
      if (!s_axis_tvalid || in_fire) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 19) == 0) begin
          send_gap <= $urandom_range(1, 16);
          s_axis_tvalid <= 1'b0;
        end else if (pending_chars.size() != 0 && !hold_send) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_chars[0].char_code;
          s_axis_tlast  <= pending_chars[0].last;
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink ready with random stall bursts.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= (recv_gap == 1);
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(1, 16);
      m_axis_tready <= 1'b0;
    end else m_axis_tready <= 1'b1;
  end

  // Monitor: checks result words and runs the watchdog.
  always @(posedge clk_i) begin
    result_word_t want;
    if (!rst_ni) quiet_cycles <= 0;
    else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h",
                   $realtime, m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== want.value) begin
            $display("%0t: result_value mismatch, expected %0d, actual %0d", $realtime,
                     $signed(want.value), $signed(m_axis_tdata[31:0]));
            failed = 1'b1;
          end
          if (m_axis_tdata[34:32] !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $realtime,
                     want.status, m_axis_tdata[34:32]);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
